### hw/rtl/rsd_pkg.sv
// Shared types and constants of the run-length sprite span decoder.
// Used by the config block, controller, datapath and top level; no dependencies.
package rsd_pkg;

	// default sizing of the top level
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_RIGHT_CLIP = 639;

	// field widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PICTURE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PICTURE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRAW_MODE      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_TOP       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_BOTTOM    = 3'd6;

	// draw modes
	localparam logic [1:0] MODE_BUFFER      = 2'd0;
	localparam logic [1:0] MODE_OPAQUE      = 2'd1;
	localparam logic [1:0] MODE_TRANSPARENT = 2'd2;
	localparam logic [1:0] MODE_LETTERBOX   = 2'd3;

	// transparent palette index
	localparam logic [7:0] COLOUR_CLEAR = 8'hFF;

	// register reset values
	localparam logic [10:0] RST_PICTURE_WIDTH  = 11'd640;
	localparam logic [10:0] RST_PICTURE_HEIGHT = 11'd480;
	localparam logic [10:0] RST_ORIGIN_X       = 11'd0;
	localparam logic [9:0]  RST_ORIGIN_Y       = 10'd0;
	localparam logic [1:0]  RST_DRAW_MODE      = MODE_OPAQUE;
	localparam logic [9:0]  RST_BAND_TOP       = 10'd0;
	localparam logic [10:0] RST_BAND_BOTTOM    = 11'd1024;

	// live configuration, width and height already saturated
	typedef struct packed {
		logic [10:0] width;
		logic [10:0] height;
		logic [10:0] origin_x;   // two's complement
		logic [9:0]  origin_y;
		logic [1:0]  mode;
		logic [9:0]  band_top;
		logic [10:0] band_bottom;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // take a new run
		logic step;        // evaluate one line segment
		logic push;        // move pending span to output register
		logic push_last;   // pushed span closes the run
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic it_final;    // current segment ends the run
		logic it_show;     // current segment yields a visible span
		logic pend_v;      // a span is waiting in the pending register
		logic out_free;    // output register can take a beat this cycle
	} sts_t;

endpackage

### hw/rtl/rsd_cfg.sv
// Configuration register file of the span decoder, with width/height saturation.
// Depends on rsd_pkg.
module rsd_cfg import rsd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [10:0] width_q, height_q, origin_x_q, band_bottom_q;
	logic [9:0]  origin_y_q, band_top_q;
	logic [1:0]  mode_q;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q       <= RST_PICTURE_WIDTH;
			height_q      <= RST_PICTURE_HEIGHT;
			origin_x_q    <= RST_ORIGIN_X;
			origin_y_q    <= RST_ORIGIN_Y;
			mode_q        <= RST_DRAW_MODE;
			band_top_q    <= RST_BAND_TOP;
			band_bottom_q <= RST_BAND_BOTTOM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PICTURE_WIDTH:  width_q       <= cfg_data;
				REG_PICTURE_HEIGHT: height_q      <= cfg_data;
				REG_ORIGIN_X:       origin_x_q    <= cfg_data;
				REG_ORIGIN_Y:       origin_y_q    <= cfg_data[9:0];
				REG_DRAW_MODE:      mode_q        <= cfg_data[1:0];
				REG_BAND_TOP:       band_top_q    <= cfg_data[9:0];
				REG_BAND_BOTTOM:    band_bottom_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp width to 8..MAX_WIDTH and height to 1..MAX_HEIGHT
	always_comb begin
		cfg.width = width_q;
		if (width_q < 11'd8)
			cfg.width = 11'd8;
		else if ({2'b00, width_q} > 13'(MAX_WIDTH))
			cfg.width = 11'(MAX_WIDTH);
		cfg.height = height_q;
		if (height_q == 11'd0)
			cfg.height = 11'd1;
		else if ({2'b00, height_q} > 13'(MAX_HEIGHT))
			cfg.height = 11'(MAX_HEIGHT);
		cfg.origin_x    = origin_x_q;
		cfg.origin_y    = origin_y_q;
		cfg.mode        = mode_q;
		cfg.band_top    = band_top_q;
		cfg.band_bottom = band_bottom_q;
	end

endmodule

### hw/rtl/rsd_ctrl.sv
// Run sequencer of the span decoder: accepts a run, steps line segments, flushes the last span.
// Depends on rsd_pkg.
module rsd_ctrl import rsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_RUN   = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   step_ok;

	assign in_stall = (state_q != S_IDLE);

	// a visible segment needs room to retire the older pending span
	assign step_ok = !(sts.it_show && sts.pend_v && !sts.out_free);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.step      = 1'b0;
		cmd.push      = 1'b0;
		cmd.push_last = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				if (step_ok) begin
					cmd.step = 1'b1;
					cmd.push = sts.it_show && sts.pend_v;
					if (sts.it_final)
						state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (!sts.pend_v) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.push      = 1'b1;
					cmd.push_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

endmodule

### hw/rtl/rsd_dp.sv
// Datapath of the span decoder: picture position, one line segment per step, clipping,
// pending span register and output register. Depends on rsd_pkg.
module rsd_dp import rsd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int RIGHT_CLIP = DEF_RIGHT_CLIP
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        start_picture,
	input  logic [7:0]  run_length,
	input  logic [7:0]  run_colour,
	input  logic        out_stall,
	output logic        out_valid,
	output logic [11:0] span_x,
	output logic [10:0] span_y,
	output logic [10:0] span_count,
	output logic [7:0]  span_colour,
	output logic        last_span
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int WW = ((CW > 11) ? CW : 11) + 1;
	localparam int HW = ((RW > 11) ? RW : 11) + 1;
	localparam int XW = WW + 2;
	localparam logic signed [XW-1:0] X_RMAX = XW'(RIGHT_CLIP - 1);
	localparam logic signed [XW-1:0] X_LMIN = XW'(1);

	// position and run state
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          fin_q;
	logic [8:0]    rem_q;
	logic [7:0]    colour_q;

	// pending span, waits for the next one to learn if it is last
	logic          pend_v_q;
	logic [11:0]   pend_x_q;
	logic [10:0]   pend_y_q;
	logic [10:0]   pend_cnt_q;

	logic          out_valid_q;

	logic [WW-1:0] col_w, wd_w, rem_w, avail, n_w, colsum;
	logic [8:0]    n9;
	logic [HW-1:0] row_w, ht_w, row_inc_w;
	logic [RW-1:0] row_inc;
	logic          at_end, past_col, wraps, fin_wrap, consume;
	logic          is_buf, vis, trans_hide, band_hide;
	logic signed [XW-1:0] x_org, x_col, x_n, x0, x1, x0c, x1c, x_cnt;
	logic [10:0]   y_val;

	// segment length on the current line
	assign col_w     = WW'(col_q);
	assign wd_w      = WW'(cfg.width);
	assign rem_w     = WW'(rem_q);
	assign avail     = wd_w - col_w;
	assign n_w       = (avail < rem_w) ? avail : rem_w;
	assign n9        = n_w[8:0];
	assign colsum    = col_w + n_w;
	assign row_w     = HW'(row_q);
	assign ht_w      = HW'(cfg.height);
	assign row_inc   = row_q + 1'b1;
	assign row_inc_w = HW'(row_inc);

	assign at_end   = (row_w >= ht_w);
	assign past_col = (col_w >= wd_w);
	assign wraps    = (colsum >= wd_w);
	assign fin_wrap = (row_inc_w >= ht_w);
	assign consume  = !fin_q && !at_end && !past_col;

	// screen columns and clip window
	assign is_buf = (cfg.mode == MODE_BUFFER);
	assign x_org  = XW'($signed(cfg.origin_x));
	assign x_col  = $signed(XW'(col_q));
	assign x_n    = $signed(XW'(n9));
	assign x0     = is_buf ? x_col : (x_org + x_col);
	assign x1     = x0 + x_n - X_LMIN;
	assign x0c    = (!is_buf && (x0 < X_LMIN)) ? X_LMIN : x0;
	assign x1c    = (!is_buf && (x1 > X_RMAX)) ? X_RMAX : x1;
	assign x_cnt  = x1c - x0c + X_LMIN;
	assign vis    = (x1c >= x0c);

	assign trans_hide = (cfg.mode == MODE_TRANSPARENT) && (colour_q == COLOUR_CLEAR);
	assign band_hide  = (cfg.mode == MODE_LETTERBOX) &&
		!((row_w > HW'(cfg.band_top)) && (row_w < HW'(cfg.band_bottom)));

	assign y_val = is_buf ? 11'(row_q) : 11'(HW'(cfg.origin_y) + row_w);

	assign sts.it_final = fin_q || at_end || (consume && (n_w == rem_w));
	assign sts.it_show  = consume && vis && !trans_hide && !band_hide;
	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	// position update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			fin_q <= 1'b0;
		end else if (cmd.load) begin
			if (start_picture) begin
				col_q <= '0;
				row_q <= '0;
				fin_q <= 1'b0;
			end
		end else if (cmd.step && !fin_q) begin
			if (at_end) begin
				fin_q <= 1'b1;
			end else if (past_col) begin
				col_q <= '0;
				row_q <= row_inc;
			end else if (wraps) begin
				col_q <= '0;
				row_q <= row_inc;
				fin_q <= fin_wrap;
			end else begin
				col_q <= colsum[CW-1:0];
			end
		end
	end

	// run payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q    <= (run_length == 8'd0) ? 9'd256 : {1'b0, run_length};
			colour_q <= run_colour;
		end else if (cmd.step && consume) begin
			rem_q <= rem_q - n9;
		end
	end

	// pending span
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_v_q <= 1'b0;
		else if (cmd.step && sts.it_show)
			pend_v_q <= 1'b1;
		else if (cmd.push)
			pend_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.step && sts.it_show) begin
			pend_x_q   <= x0c[11:0];
			pend_y_q   <= y_val;
			pend_cnt_q <= x_cnt[10:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.push)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			span_x      <= pend_x_q;
			span_y      <= pend_y_q;
			span_count  <= pend_cnt_q;
			span_colour <= colour_q;
			last_span   <= cmd.push_last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### hw/rtl/rle_sprite_span_decoder.sv
// Run-length sprite span decoder, top level. A run is taken in IDLE, then the datapath
// walks one picture line segment per cycle unless a visible segment finds the output
// register full with a span pending; FLUSH then retires the final span, if one is pending.
// A span is pushed out by the next visible segment or FLUSH. Output register holds one beat.
// arst_n clears position, picture-end flag, sequencer and valid flags; registers return
// to their documented reset values. Depends on rsd_pkg, rsd_cfg, rsd_ctrl, rsd_dp.
module rle_sprite_span_decoder import rsd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int RIGHT_CLIP = DEF_RIGHT_CLIP
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  start_picture,
	input  logic [7:0]            run_length,
	input  logic [7:0]            run_colour,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [11:0]    span_x,
	output logic [10:0]           span_y,
	output logic [10:0]           span_count,
	output logic [7:0]            span_colour,
	output logic                  last_span,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t        cfg;
	cmd_t        cmd;
	sts_t        sts;
	logic [11:0] span_x_raw;

	rsd_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	rsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsd_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.RIGHT_CLIP (RIGHT_CLIP)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.start_picture (start_picture),
		.run_length    (run_length),
		.run_colour    (run_colour),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.span_x        (span_x_raw),
		.span_y        (span_y),
		.span_count    (span_count),
		.span_colour   (span_colour),
		.last_span     (last_span)
	);

	assign span_x = $signed(span_x_raw);

`ifndef SYNTH
	// a new run never finds a span of the previous run still pending
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !sts.pend_v)
		else $error("run accepted with span still pending");

	// the output register is only overwritten when its beat is gone
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> sts.out_free)
		else $error("output register overwritten");

	// every delivered span covers at least one pixel
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (span_count != 11'd0))
		else $error("empty span delivered");
`endif

endmodule

### tb/sv/rle_sprite_span_decoder_test.sv
// Self-checking testbench for rle_sprite_span_decoder: directed and random runs, span checks.
// A scoreboard class predicts the spans of every accepted run; depends on rsd_pkg and the RTL.
module rle_sprite_span_decoder_test;
	import rsd_pkg::*;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 80;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_RUNS   = 160;
	localparam int MAX_SEGMENTS  = 66;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [11:0] x;
		logic [10:0]        y;
		logic [10:0]        count;
		logic [7:0]         colour;
		logic               last;
	} span_t;

	// span predictor and queue of spans still due from the block
	class span_scoreboard;
		span_t              due[$];
		int                 errors;
		logic [10:0]        pic_w, pic_h, band_hi;
		logic signed [10:0] org_x;
		logic [9:0]         org_y, band_lo;
		logic [1:0]         mode;
		int                 col, row;
		bit                 done;

		function new();
			pic_w   = RST_PICTURE_WIDTH;
			pic_h   = RST_PICTURE_HEIGHT;
			org_x   = RST_ORIGIN_X;
			org_y   = RST_ORIGIN_Y;
			mode    = RST_DRAW_MODE;
			band_lo = RST_BAND_TOP;
			band_hi = RST_BAND_BOTTOM;
			col     = 0;
			row     = 0;
			done    = 1'b0;
			errors  = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_PICTURE_WIDTH:  pic_w = data;
				REG_PICTURE_HEIGHT: pic_h = data;
				REG_ORIGIN_X:       org_x = data;
				REG_ORIGIN_Y:       org_y = data[9:0];
				REG_DRAW_MODE:      mode = data[1:0];
				REG_BAND_TOP:       band_lo = data[9:0];
				REG_BAND_BOTTOM:    band_hi = data;
				default: ;
			endcase
		endfunction

		// walk the run over picture lines; returns 1 if the run consumed any picture pixels
		function bit note_run(bit start, logic [7:0] len, logic [7:0] colour);
			int    w, h, left, n, x0, x1, yy, first, guard;
			bit    show, used;
			span_t s;
			w = (pic_w < 8) ? 8 : (pic_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(pic_w);
			h = (pic_h < 1) ? 1 : (pic_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(pic_h);
			if (start) begin
				col  = 0;
				row  = 0;
				done = 1'b0;
			end
			left  = (len == 0) ? 256 : int'(len);
			first = due.size();
			used  = 1'b0;
			for (guard = 0; guard < MAX_SEGMENTS && left > 0; guard++) begin
				if (done)
					break;
				if (row >= h) begin
					done = 1'b1;
					break;
				end
				// width lowered under the current column: wrap first
				if (col >= w) begin
					col = 0;
					row++;
					continue;
				end
				used = 1'b1;
				n = w - col;
				if (n > left)
					n = left;
				show = 1'b1;
				if (mode == MODE_BUFFER) begin
					x0 = col;
					x1 = col + n - 1;
					yy = row;
				end else begin
					x0 = int'(org_x) + col;
					x1 = x0 + n - 1;
					yy = int'(org_y) + row;
					if (x0 < 1)
						x0 = 1;
					if (x1 > DEF_RIGHT_CLIP - 1)
						x1 = DEF_RIGHT_CLIP - 1;
					if (x1 < x0)
						show = 1'b0;
					if (mode == MODE_TRANSPARENT && colour == COLOUR_CLEAR)
						show = 1'b0;
					if (mode == MODE_LETTERBOX && !(row > int'(band_lo) && row < int'(band_hi)))
						show = 1'b0;
				end
				if (show) begin
					s.x      = x0[11:0];
					s.y      = yy[10:0];
					n        = x1 - x0 + 1;
					s.count  = n[10:0];
					s.colour = colour;
					s.last   = 1'b0;
					due.push_back(s);
					n = w - col;
					if (n > left)
						n = left;
				end
				left -= n;
				col  += n;
				if (col >= w) begin
					col = 0;
					row++;
					if (row >= h)
						done = 1'b1;
				end
			end
			if (due.size() > first)
				due[due.size() - 1].last = 1'b1;
			return used;
		endfunction

		task report(string msg);
			$display("[%0t] span mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_span(logic signed [11:0] x, logic [10:0] y, logic [10:0] cnt,
			logic [7:0] colour, logic last);
			span_t want;
			if (due.size() == 0) begin
				report($sformatf("unexpected span x=%0d y=%0d count=%0d", x, y, cnt));
				return;
			end
			want = due.pop_front();
			if (x !== want.x)
				report($sformatf("span_x got %0d want %0d", x, want.x));
			if (y !== want.y)
				report($sformatf("span_y got %0d want %0d", y, want.y));
			if (cnt !== want.count)
				report($sformatf("span_count got %0d want %0d", cnt, want.count));
			if (colour !== want.colour)
				report($sformatf("span_colour got %0d want %0d", colour, want.colour));
			if (last !== want.last)
				report($sformatf("last_span got %0b want %0b", last, want.last));
		endtask
	endclass

	bit                    clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  start_picture = 1'b0;
	logic [7:0]            run_length = '0;
	logic [7:0]            run_colour = '0;
	logic                  out_stall = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_stall, out_valid, last_span, cfg_ready;
	logic signed [11:0]    span_x;
	logic [10:0]           span_y, span_count;
	logic [7:0]            span_colour;

	span_scoreboard sb = new();
	bit             quiet;
	bit             hold_ask;
	int             hold_left;
	int             cycles;
	int             live_runs;

	rle_sprite_span_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_picture(start_picture),
		.run_length   (run_length),
		.run_colour   (run_colour),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.span_x       (span_x),
		.span_y       (span_y),
		.span_count   (span_count),
		.span_colour  (span_colour),
		.last_span    (last_span),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run-time limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("rle_sprite_span_decoder_test: FAIL");
			$finish;
		end
	end

	// output side stall: random, quiet stretch, or one long hold-off
	always @(negedge clk) begin
		if (hold_ask) begin
			hold_ask  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= !quiet && ($urandom_range(0, 99) < 28);
	end

	// span beat monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_span(span_x, span_y, span_count, span_colour, last_span);
	end

	task automatic put_run(bit start, logic [7:0] len, logic [7:0] colour);
		if (!quiet && $urandom_range(0, 99) < 28) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(0, 2)) @(negedge clk);
		end
		@(negedge clk);
		in_valid      <= 1'b1;
		start_picture <= start;
		run_length    <= len;
		run_colour    <= colour;
		do @(posedge clk); while (in_stall);
		if (sb.note_run(start, len, colour))
			live_runs++;
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// drain all due spans, then give a run with no visible spans time to finish
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_len();
		return 8'($urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_colour();
		return ($urandom_range(0, 4) == 0) ? COLOUR_CLEAR : 8'($urandom_range(0, 255));
	endfunction

	// one random setting followed by a few pictures, mostly well formed
	task automatic random_phase(int phase_no);
		int          w, h, ox, total, sent, runs, pics, n;
		bit          start;
		logic [7:0]  len;
		logic [10:0] wr, hr;
		case ($urandom_range(0, 9))
			0:       wr = 11'($urandom_range(0, 7));
			1:       wr = 11'($urandom_range(1025, 2047));
			2:       wr = 11'(DEF_MAX_WIDTH);
			3:       wr = 11'd640;
			default: wr = 11'($urandom_range(8, 48));
		endcase
		case ($urandom_range(0, 7))
			0:       hr = 11'd0;
			1:       hr = 11'($urandom_range(1025, 2047));
			default: hr = 11'($urandom_range(1, 6));
		endcase
		case ($urandom_range(0, 4))
			0:       ox = $urandom_range(0, 2047);
			1:       ox = $urandom_range(600, 640);
			default: ox = int'($urandom_range(0, 40)) - 20;
		endcase
		set_reg(REG_PICTURE_WIDTH, wr);
		set_reg(REG_PICTURE_HEIGHT, hr);
		set_reg(REG_ORIGIN_X, ox[10:0]);
		set_reg(REG_ORIGIN_Y, 11'($urandom_range(0, 1023)));
		set_reg(REG_DRAW_MODE, 11'($urandom_range(0, 3)));
		set_reg(REG_BAND_TOP, 11'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
			: $urandom_range(0, 4)));
		case ($urandom_range(0, 3))
			0:       set_reg(REG_BAND_BOTTOM, 11'd1024);
			1:       set_reg(REG_BAND_BOTTOM, 11'($urandom_range(0, 2047)));
			default: set_reg(REG_BAND_BOTTOM, 11'($urandom_range(0, 8)));
		endcase
		w = (wr < 8) ? 8 : (wr > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(wr);
		h = (hr < 1) ? 1 : (hr > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(hr);
		quiet = (phase_no == 1);
		if (phase_no == 2)
			hold_ask = 1'b1;
		pics = $urandom_range(1, 3);
		repeat (pics) begin
			total = w * h;
			sent  = 0;
			runs  = 0;
			while (sent < total && runs < 20) begin
				len   = pick_len();
				start = (runs == 0) || ($urandom_range(0, 99) < 4);
				n     = (len == 0) ? 256 : int'(len);
				put_run(start, len, pick_colour());
				sent = start ? n : sent + n;
				runs++;
			end
			// spill past the picture end now and then
			if ($urandom_range(0, 2) == 0)
				put_run(1'b0, pick_len(), pick_colour());
		end
		settle();
		quiet = 1'b0;
	endtask

	initial begin
		int phase_no;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset setting: left clip, opaque 255, line end and right clip
		put_run(1'b1, 8'd0, 8'h00);
		put_run(1'b0, 8'd255, 8'hFF);
		put_run(1'b0, 8'd1, 8'h80);
		put_run(1'b0, 8'd0, 8'h7F);
		settle();

		// narrowest buffer decode, runs past the picture end
		set_reg(REG_PICTURE_WIDTH, 11'd8);
		set_reg(REG_PICTURE_HEIGHT, 11'd2);
		set_reg(REG_DRAW_MODE, 11'(MODE_BUFFER));
		put_run(1'b1, 8'd0, 8'h55);
		put_run(1'b0, 8'd5, 8'hAA);
		put_run(1'b1, 8'd3, 8'h0F);
		settle();

		// transparent draw on a saturated width and height, bottom origin row
		set_reg(REG_PICTURE_WIDTH, 11'd2047);
		set_reg(REG_PICTURE_HEIGHT, 11'd0);
		set_reg(REG_DRAW_MODE, 11'(MODE_TRANSPARENT));
		set_reg(REG_ORIGIN_X, 11'(-100));
		set_reg(REG_ORIGIN_Y, 11'd1023);
		put_run(1'b1, 8'd0, COLOUR_CLEAR);
		put_run(1'b0, 8'd0, 8'h01);
		put_run(1'b0, 8'd0, 8'hFE);
		put_run(1'b0, 8'd0, 8'h33);
		put_run(1'b0, 8'd7, 8'h44);
		settle();

		// origin extremes put the whole run off screen; width under minimum
		set_reg(REG_PICTURE_WIDTH, 11'd3);
		set_reg(REG_PICTURE_HEIGHT, 11'd1024);
		set_reg(REG_DRAW_MODE, 11'(MODE_OPAQUE));
		set_reg(REG_ORIGIN_X, 11'd1023);
		set_reg(REG_ORIGIN_Y, 11'd0);
		put_run(1'b1, 8'd0, 8'h11);
		settle();
		set_reg(REG_ORIGIN_X, 11'h400);
		put_run(1'b0, 8'd0, 8'h22);
		settle();

		// letterbox keeps rows strictly inside the band
		set_reg(REG_PICTURE_WIDTH, 11'd16);
		set_reg(REG_ORIGIN_X, 11'd0);
		set_reg(REG_DRAW_MODE, 11'(MODE_LETTERBOX));
		set_reg(REG_BAND_TOP, 11'd1);
		set_reg(REG_BAND_BOTTOM, 11'd4);
		put_run(1'b1, 8'd0, 8'h3C);
		settle();
		set_reg(REG_BAND_TOP, 11'd1023);
		set_reg(REG_BAND_BOTTOM, 11'd2047);
		put_run(1'b1, 8'd0, 8'h5A);
		settle();

		// width lowered under the column, then height lowered under the row
		set_reg(REG_DRAW_MODE, 11'(MODE_BUFFER));
		set_reg(REG_PICTURE_WIDTH, 11'd640);
		set_reg(REG_BAND_TOP, 11'd0);
		set_reg(REG_BAND_BOTTOM, 11'd1024);
		put_run(1'b1, 8'd0, 8'hC3);
		put_run(1'b0, 8'd0, 8'h3C);
		settle();
		set_reg(REG_PICTURE_WIDTH, 11'd300);
		put_run(1'b0, 8'd10, 8'h99);
		settle();
		set_reg(REG_PICTURE_HEIGHT, 11'd1);
		put_run(1'b0, 8'd4, 8'h66);
		put_run(1'b1, 8'd200, 8'h77);
		settle();

		// unmapped register index changes nothing
		set_reg(REG_UNUSED, 11'h7FF);
		put_run(1'b0, 8'd1, 8'h00);
		settle();

		live_runs = 0;
		phase_no  = 0;
		while (live_runs < RANDOM_RUNS) begin
			random_phase(phase_no);
			phase_no++;
		end

		settle();
		if (sb.errors == 0)
			$display("rle_sprite_span_decoder_test: PASS");
		else
			$display("rle_sprite_span_decoder_test: FAIL");
		$finish;
	end

endmodule
